// ===== rtl/core/dbfb_pkg.sv =====
// Package for the double-buffered framebuffer: store geometry, reset code and action codes.
// Depends on nothing; imported by double_buffered_framebuffer.
package dbfb_pkg;

   localparam int PIXEL_CAPACITY     = 65536;
   localparam int DEFAULT_RESOLUTION = 0;

   localparam int ADDR_W  = $clog2(PIXEL_CAPACITY);
   localparam int PIXEL_W = 24;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(PIXEL_CAPACITY - 1);
   localparam logic [31:0]       CAPACITY_32 = 32'(PIXEL_CAPACITY);
   localparam logic [7:0]        DEFAULT_RES = 8'(DEFAULT_RESOLUTION);

   typedef logic [1:0] action_type;

   localparam action_type ACT_WRITE = 2'd0;
   localparam action_type ACT_READ  = 2'd1;
   localparam action_type ACT_SWAP  = 2'd2;
   localparam action_type ACT_RES   = 2'd3;

   localparam logic RESULT_PIXEL  = 1'b0;
   localparam logic RESULT_NOTICE = 1'b1;

endpackage

// ===== rtl/core/double_buffered_framebuffer.sv =====
// Double-buffered framebuffer top level: drawing and display pixel memories and their sequencer.
// Depends on dbfb_pkg for geometry and action codes.
//
// Usage. A command beat is taken at a rising edge where start is high and busy is low.
// A pixel write stores its color in the drawing memory in that same cycle and leaves
// busy low, so writes can be issued one per cycle. A pixel read raises busy while
// the display memory is read; the result beat is on the rsp_ ports in the cycle
// where busy drops again, so a read must finish before the next command beat is taken.
// A swap walks both memories, one pixel a cycle, reading the drawing memory and
// writing the display memory in the cycle after each read; busy stays high through
// the walk and the drain state after it. A resolution change records the code, then
// clears both memories and issues its notice beat in the cycle where busy drops.
// Indexes at or beyond the capacity are dropped on write and flagged on read with
// a zero color.
// Each result beat is shown for exactly one cycle, marked by rsp_valid; the
// receiver cannot stall it, and nothing is held back for it.
// Reset starts the same clearing pass over both memories: busy is high through that
// pass after reset is released, and no beat results from it.
// The pace of swap and clear is set by the single write port of each memory.
module double_buffered_framebuffer
   import dbfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_pixel_index,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_resolution_code,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_index_out_of_range,
   output logic [7:0]  rsp_new_resolution
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_COPY  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   // The two pixel memories, each with one write port and one registered read port.
   logic [PIXEL_W-1:0] drawing_mem [PIXEL_CAPACITY];
   logic [PIXEL_W-1:0] display_mem [PIXEL_CAPACITY];

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic               notice_ff, notice_in;
   logic [7:0]         cur_res_ff, cur_res_in;
   logic               oor_ff, oor_in;

   // Copy pipeline: the drawing memory word read last cycle goes to this display address.
   logic               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;

   logic [PIXEL_W-1:0] drawing_q_ff;
   logic [PIXEL_W-1:0] display_q_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [PIXEL_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_oor_ff, rsp_oor_in;
   logic [7:0]         rsp_res_ff, rsp_res_in;

   // Memory port controls.
   logic               draw_we, draw_re, disp_we, disp_re;
   logic [ADDR_W-1:0]  draw_waddr, draw_raddr, disp_waddr, disp_raddr;
   logic [PIXEL_W-1:0] draw_wdata, disp_wdata;

   logic               accept;
   logic               in_range;
   logic [ADDR_W-1:0]  req_addr;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = req_pixel_index < CAPACITY_32;
   assign req_addr = req_pixel_index[ADDR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      notice_in    = notice_ff;
      cur_res_in   = cur_res_ff;
      oor_in       = oor_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_color_in = rsp_color_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_res_in   = rsp_res_ff;

      draw_we    = 1'b0;
      draw_waddr = req_addr;
      draw_wdata = {req_red_in, req_green_in, req_blue_in};
      draw_re    = 1'b0;
      draw_raddr = cnt_ff;
      disp_re    = 1'b0;
      disp_raddr = req_addr;
      // A pending copy word is written whatever the state; only copy sets it.
      disp_we    = wr_pend_ff;
      disp_waddr = wr_addr_ff;
      disp_wdata = drawing_q_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_WRITE: begin
                     draw_we = in_range;
                  end
                  ACT_READ: begin
                     disp_re  = in_range;
                     oor_in   = !in_range;
                     state_in = ST_READ;
                  end
                  ACT_SWAP: begin
                     cnt_in   = '0;
                     state_in = ST_COPY;
                  end
                  ACT_RES: begin
                     cur_res_in = req_resolution_code;
                     notice_in  = 1'b1;
                     cnt_in     = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RESULT_PIXEL;
            rsp_color_in = oor_ff ? '0 : display_q_ff;
            rsp_oor_in   = oor_ff;
            rsp_res_in   = '0;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            draw_re    = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = cnt_ff;
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            draw_we    = 1'b1;
            draw_waddr = cnt_ff;
            draw_wdata = '0;
            disp_we    = 1'b1;
            disp_waddr = cnt_ff;
            disp_wdata = '0;
            if (cnt_ff == LAST_ADDR) begin
               state_in  = ST_IDLE;
               notice_in = 1'b0;
               if (notice_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RESULT_NOTICE;
                  rsp_color_in = '0;
                  rsp_oor_in   = 1'b0;
                  rsp_res_in   = cur_res_ff;
               end
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memories: synchronous write, registered read.
   always_ff @(posedge clock) begin
      if (draw_we) begin
         drawing_mem[draw_waddr] <= draw_wdata;
      end
      if (draw_re) begin
         drawing_q_ff <= drawing_mem[draw_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (disp_we) begin
         display_mem[disp_waddr] <= disp_wdata;
      end
      if (disp_re) begin
         display_q_ff <= display_mem[disp_raddr];
      end
   end

   // Control registers; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         notice_ff    <= 1'b0;
         cur_res_ff   <= DEFAULT_RES;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         notice_ff    <= notice_in;
         cur_res_ff   <= cur_res_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      oor_ff       <= oor_in;
      wr_addr_ff   <= wr_addr_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_color_ff <= rsp_color_in;
      rsp_oor_ff   <= rsp_oor_in;
      rsp_res_ff   <= rsp_res_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = rsp_kind_ff;
   assign rsp_red_out            = rsp_color_ff[23:16];
   assign rsp_green_out          = rsp_color_ff[15:8];
   assign rsp_blue_out           = rsp_color_ff[7:0];
   assign rsp_index_out_of_range = rsp_oor_ff;
   assign rsp_new_resolution     = rsp_res_ff;

   // A result beat only ever follows a read cycle or the last clearing cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_CLEAR))
      else $error("result beat without a read or clear behind it");

   // Copy writes into the display memory happen only during a swap walk.
   a_copy_write: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_COPY || state_ff == ST_DRAIN))
      else $error("pending copy write outside a swap");

   // An accepted read keeps the block busy for exactly the next cycle.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_READ) |=> (busy ##1 (!busy && rsp_valid)))
      else $error("read did not finish in two cycles");

   // A notice never carries the out-of-range flag.
   a_notice_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == RESULT_NOTICE) |-> !rsp_index_out_of_range)
      else $error("notice beat flagged out of range");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for double_buffered_framebuffer: a directed command table, then random beats.
// Depends on dbfb_pkg and the RTL; keeps its own copy of both pixel stores to predict read data.
module tb_top
   import dbfb_pkg::*;
;

   // The random part runs a few hundred beats. Every HEAVY_SPACING-th beat is a swap or a
   // resolution change, since each of those walks a whole store.
   localparam int     RANDOM_BEATS  = 725;
   localparam int     HEAVY_SPACING = 180;
   localparam int     DIRECTED_ROWS = 25;
   localparam int     TAIL_CYCLES   = 16;
   // The slowest correct run: the clearing pass after reset, nine full-store walks, and every
   // beat behind the longest idle gap. The limit is over four times that run.
   localparam longint CYCLE_LIMIT   = 3_000_000;

   typedef struct packed {
      action_type  action;
      logic [31:0] pixel_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  code;
   } frame_cmd_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       out_of_range;
      logic [7:0] resolution;
   } frame_reply_type;

   // A directed row either carries its expected reply typed in (typed = 1), or leaves the
   // reply to the store model.
   typedef struct packed {
      frame_cmd_type   cmd;
      bit              typed;
      frame_reply_type reply;
   } plan_row_type;

   localparam frame_reply_type NO_REPLY    = '0;
   localparam frame_reply_type BLANK_PIXEL = '{RESULT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00};
   localparam frame_reply_type OFF_FRAME   = '{RESULT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00};

   // Directed part. Reads after reset and after a clear must return black; reads past the
   // end of the store are flagged with a black color; writes past the end change nothing.
   // The resolution field carries a nonzero pattern on other actions to show it is ignored.
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{'{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, BLANK_PIXEL},
      '{'{ACT_READ,  32'h0000_FFFF, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, BLANK_PIXEL},
      '{'{ACT_READ,  32'h0001_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, OFF_FRAME},
      '{'{ACT_READ,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, OFF_FRAME},
      '{'{ACT_WRITE, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_WRITE, 32'h0000_FFFF, 8'hFF, 8'h00, 8'hFF, 8'hA5}, 1'b0, NO_REPLY},
      '{'{ACT_WRITE, 32'h0001_0000, 8'hAA, 8'h55, 8'hAA, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_WRITE, 32'hFFFF_FFFF, 8'h55, 8'hAA, 8'h55, 8'hFF}, 1'b0, NO_REPLY},
      '{'{ACT_WRITE, 32'h0000_8000, 8'h00, 8'hFF, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'h5A}, 1'b1, BLANK_PIXEL},
      '{'{ACT_SWAP,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_FFFF, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_8000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0001_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, OFF_FRAME},
      '{'{ACT_WRITE, 32'h0000_0000, 8'h12, 8'h34, 8'h56, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_SWAP,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_RES,   32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1,
        '{RESULT_NOTICE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF}},
      '{'{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, BLANK_PIXEL},
      '{'{ACT_SWAP,  32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_REPLY},
      '{'{ACT_READ,  32'h0000_FFFF, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, BLANK_PIXEL},
      '{'{ACT_RES,   32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1,
        '{RESULT_NOTICE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}},
      '{'{ACT_READ,  32'h0000_8000, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, BLANK_PIXEL}
   };

   logic        clock                  = 1'b0;
   logic        reset                  = 1'b1;
   logic        start                  = 1'b0;
   logic        busy;
   logic [1:0]  req_action             = ACT_WRITE;
   logic [31:0] req_pixel_index        = '0;
   logic [7:0]  req_red_in             = '0;
   logic [7:0]  req_green_in           = '0;
   logic [7:0]  req_blue_in            = '0;
   logic [7:0]  req_resolution_code    = '0;
   logic        rsp_valid;
   logic        rsp_result_kind;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_index_out_of_range;
   logic [7:0]  rsp_new_resolution;

   double_buffered_framebuffer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Our own copy of the block's state: what has been drawn, what is on show, and the
   // resolution code last applied.
   logic [PIXEL_W-1:0] drawn_pixels [PIXEL_CAPACITY];
   logic [PIXEL_W-1:0] shown_pixels [PIXEL_CAPACITY];
   logic [7:0]         resolution_now;

   // Replies still owed by the block, oldest first.
   frame_reply_type owed_replies [$];
   int              mismatches  = 0;
   longint          cycle_count = 0;

   task automatic wipe_stores();
      foreach (drawn_pixels[i]) begin
         drawn_pixels[i] = '0;
         shown_pixels[i] = '0;
      end
   endtask

   // Applies one accepted command to the store copy and works out the reply it owes, if any.
   task automatic predict_frame_op(input frame_cmd_type cmd, output bit answers,
                                   output frame_reply_type reply);
      logic              in_range;
      logic [ADDR_W-1:0] addr;
      in_range = cmd.pixel_index < CAPACITY_32;
      addr     = cmd.pixel_index[ADDR_W-1:0];
      reply    = '0;
      answers  = 1'b0;
      case (cmd.action)
         ACT_WRITE: begin
            if (in_range) begin
               drawn_pixels[addr] = {cmd.red, cmd.green, cmd.blue};
            end
         end
         ACT_READ: begin
            answers    = 1'b1;
            reply.kind = RESULT_PIXEL;
            if (in_range) begin
               {reply.red, reply.green, reply.blue} = shown_pixels[addr];
            end else begin
               reply.out_of_range = 1'b1;
            end
         end
         ACT_SWAP: begin
            shown_pixels = drawn_pixels;
         end
         ACT_RES: begin
            wipe_stores();
            resolution_now   = cmd.code;
            answers          = 1'b1;
            reply.kind       = RESULT_NOTICE;
            reply.resolution = resolution_now;
         end
      endcase
   endtask

   // Drives one command beat at a falling edge, after the requested number of idle cycles,
   // and holds it until a rising edge finds busy low. The reply owed is queued at that edge.
   task automatic issue_beat(input frame_cmd_type cmd, input int idle_cycles,
                             input bit typed, input frame_reply_type typed_reply);
      bit              answers;
      frame_reply_type reply;
      if (idle_cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (idle_cycles - 1) @(negedge clock);
      end
      @(negedge clock);
      start               <= 1'b1;
      req_action          <= cmd.action;
      req_pixel_index     <= cmd.pixel_index;
      req_red_in          <= cmd.red;
      req_green_in        <= cmd.green;
      req_blue_in         <= cmd.blue;
      req_resolution_code <= cmd.code;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_frame_op(cmd, answers, reply);
      if (answers) begin
         owed_replies.push_back(typed ? typed_reply : reply);
      end
   endtask

   // Takes start down so nothing is accepted twice, then waits for every owed reply.
   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   // Idle gaps: most beats follow at once, many after a short pause, a few after a long one.
   function automatic int pick_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pixel addresses cluster in two small windows, at the bottom and the top of the store,
   // so that reads land on pixels written and swapped earlier. The rest are fully random
   // words, which also exercise the high index bits, and the boundary values.
   function automatic logic [31:0] pick_index();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 32'($urandom_range(0, 31));
      if (roll < 85) return CAPACITY_32 - 32'($urandom_range(1, 32));
      if (roll < 95) return $urandom();
      case ($urandom_range(0, 3))
         0:       return CAPACITY_32;
         1:       return '1;
         2:       return 32'(LAST_ADDR);
         default: return '0;
      endcase
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // Each reply beat is on the rsp_ ports for one cycle and is taken at the rising edge
   // that ends it; it is compared field by field with the oldest reply owed.
   always @(posedge clock) begin
      frame_reply_type want;
      if (rsp_valid === 1'b1) begin
         if (owed_replies.size() == 0) begin
            mismatches++;
            $display("%0t: reply beat with nothing owed, expected none, got kind %0h",
                     $time, rsp_result_kind);
         end else begin
            want = owed_replies.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
            check_field("red_out", 32'(want.red), 32'(rsp_red_out));
            check_field("green_out", 32'(want.green), 32'(rsp_green_out));
            check_field("blue_out", 32'(want.blue), 32'(rsp_blue_out));
            check_field("index_out_of_range", 32'(want.out_of_range),
                        32'(rsp_index_out_of_range));
            check_field("new_resolution", 32'(want.resolution), 32'(rsp_new_resolution));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d replies owed", $time, owed_replies.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      frame_cmd_type cmd;
      int            notice_slot;

      wipe_stores();
      resolution_now = DEFAULT_RES;

      // Reset is held high from the start and released at a falling edge. The block then clears
      // both stores on its own, with busy high, so the first beat simply waits for busy to drop.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[row]) begin
         issue_beat(directed_plan[row].cmd, pick_idle(), directed_plan[row].typed,
                    directed_plan[row].reply);
      end

      // Random part. Writes and reads on the two address windows make up nearly all of it;
      // four beats at fixed spacing walk the whole store, one of them a resolution change
      // and the rest swaps, so that read data keeps moving from one store to the other.
      notice_slot = $urandom_range(0, 3);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         cmd.pixel_index = pick_index();
         cmd.red         = 8'($urandom_range(0, 255));
         cmd.green       = 8'($urandom_range(0, 255));
         cmd.blue        = 8'($urandom_range(0, 255));
         cmd.code        = 8'($urandom_range(0, 255));
         if (n % HEAVY_SPACING == HEAVY_SPACING - 1) begin
            cmd.action = (n / HEAVY_SPACING == notice_slot) ? ACT_RES : ACT_SWAP;
         end else if ($urandom_range(0, 1) == 0) begin
            cmd.action = ACT_WRITE;
         end else begin
            cmd.action = ACT_READ;
         end

         // Halfway through, the sender holds off until the block has answered everything.
         if (n == RANDOM_BEATS / 2) begin
            drain_replies();
         end

         // One stretch of a hundred beats goes back to back, without idle cycles.
         issue_beat(cmd, (n >= 100 && n < 200) ? 0 : pick_idle(), 1'b0, NO_REPLY);
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dbfb_pkg.sv
rtl/core/double_buffered_framebuffer.sv
bench/tb_top.sv
